### hw/rtl/cbcs_pkg.sv
// shared types, constants and codes for the colour band centroid steering block
package cbcs_pkg;

    // frame limits for counted pixels
    localparam int unsigned MAX_WIDTH  = 2048;
    localparam int unsigned MAX_HEIGHT = 2048;

    // accumulator widths
    localparam int unsigned COUNT_W = 23;
    localparam int unsigned SUM_W   = 34;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // steering constants
    localparam int DRIVE_LIMIT = 255;
    localparam int DRIVE_BASE  = 10;
    localparam int IDLE_LEFT   = 2;
    localparam int IDLE_RIGHT  = 0;
    // ceil(2^20 / 65), exact truncating quotient for |error| below 4096
    localparam logic [13:0] GAIN_RECIP = 14'd16132;
    localparam int unsigned GAIN_SHIFT = 20;

    // hsv fixed-point constants
    localparam logic [19:0] SAT_NUM = 20'd1044480;  // 255 << 12
    localparam logic [19:0] HUE_NUM = 20'd122880;   // 30 << 12
    localparam logic [8:0]  HUE_WRAP = 9'd180;

    // queue depth between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [2:0] REG_LOWER_HSV     = 3'd0;
    localparam logic [2:0] REG_UPPER_HSV     = 3'd1;
    localparam logic [2:0] REG_BAND_TOP      = 3'd2;
    localparam logic [2:0] REG_BAND_BOTTOM   = 3'd3;
    localparam logic [2:0] REG_CENTER_COLUMN = 3'd4;

    // configuration bundle
    typedef struct packed {
        logic [23:0] lower_hsv;
        logic [23:0] upper_hsv;
        logic [10:0] band_top;
        logic [10:0] band_bottom;
        logic [9:0]  center_column;
    } t_cfg;

    // classified pixel handed from front to back
    typedef struct packed {
        logic        match;
        logic [10:0] column;
        logic [10:0] row;
        logic        frame_end;
    } t_item;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_MUL,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_POP,
        B_END,
        B_DIV,
        B_ERR,
        B_MUL,
        B_EMIT
    } t_back_state;

endpackage

### hw/rtl/color_band_centroid_steering_unit.sv
// top level of the colour band centroid steering block
// usage:
//   s_axis carries one pixel per transaction: tdata holds blue, green, red,
//   column and row; tlast marks the last pixel of a frame.
//   m_axis gives one result per frame: tdata holds left drive, right drive,
//   centroid x and centroid y; tuser is the line-found flag.
//   cfg writes one of the five threshold and band registers per transaction;
//   it is always ready and should be used only while the block is idle.
// order of work:
//   the front takes each pixel through accept, the radix-2 reciprocal
//   dividers of saturation and hue, one multiply and one push before it
//   accepts the next. the back drains the queue at one pixel per cycle while
//   it is not at a frame end, where it runs a 34-step restoring divider for
//   both centroids, then error and gain steps, overlapped with the front of the next frame.
// reset: thresholds take their defaults, accumulators and queue clear.
// stall: a result waits in the output register; the back keeps draining
//   pixels and holds only when a second frame result is ready.
module color_band_centroid_steering_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // blue, green, red, column, row, zero pad
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // left_drive, right_drive, centroid_x, centroid_y
    output logic [0:0]  o_m_axis_tuser,   // line_found
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    cbcs_pkg::t_cfg  r_cfg;
    cbcs_pkg::t_item w_fitem, w_qitem;
    logic            w_push, w_full, w_pop, w_empty;
    logic [8:0]      w_left, w_right;
    logic            w_found;
    logic [10:0]     w_cx, w_cy;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_hsv     <= 24'd7564820;
            r_cfg.upper_hsv     <= 24'd12844940;
            r_cfg.band_top      <= 11'd240;
            r_cfg.band_bottom   <= 11'd390;
            r_cfg.center_column <= 10'd320;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cbcs_pkg::REG_LOWER_HSV:     r_cfg.lower_hsv     <= i_cfg_data;
                cbcs_pkg::REG_UPPER_HSV:     r_cfg.upper_hsv     <= i_cfg_data;
                cbcs_pkg::REG_BAND_TOP:      r_cfg.band_top      <= i_cfg_data[10:0];
                cbcs_pkg::REG_BAND_BOTTOM:   r_cfg.band_bottom   <= i_cfg_data[10:0];
                cbcs_pkg::REG_CENTER_COLUMN: r_cfg.center_column <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // pixel classification
    cbcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_blue      (i_s_axis_tdata[7:0]),
        .i_green     (i_s_axis_tdata[15:8]),
        .i_red       (i_s_axis_tdata[23:16]),
        .i_column    (i_s_axis_tdata[34:24]),
        .i_row       (i_s_axis_tdata[45:35]),
        .i_frame_end (i_s_axis_tlast),
        .o_push      (w_push),
        .o_item      (w_fitem),
        .i_full      (w_full)
    );

    // queue between front and back
    cbcs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_qitem),
        .o_empty (w_empty)
    );

    // accumulation and steering
    cbcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_item        (w_qitem),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_left_drive  (w_left),
        .o_right_drive (w_right),
        .o_line_found  (w_found),
        .o_centroid_x  (w_cx),
        .o_centroid_y  (w_cy)
    );

    assign o_m_axis_tdata = {w_cy, w_cx, w_right, w_left};
    assign o_m_axis_tuser = w_found;

endmodule

### hw/rtl/cbcs_front.sv
// front: hsv conversion and band test of each pixel, pushes classified items
module cbcs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cbcs_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_blue,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_red,
    input  logic [10:0]        i_column,
    input  logic [10:0]        i_row,
    input  logic               i_frame_end,
    output logic               o_push,
    output cbcs_pkg::t_item    o_item,
    input  logic               i_full
);

    cbcs_pkg::t_front_state r_state, n_state;

    logic [7:0]         r_v, r_diff;
    logic signed [11:0] r_hn;
    logic [10:0]        r_col, r_row;
    logic               r_fend;
    logic [19:0]        r_sq, r_hq;
    logic [8:0]         r_sr, r_hr;
    logic [4:0]         r_cnt;
    logic [28:0]        r_sprod;
    logic signed [30:0] r_hprod;

    logic [7:0]         w_v, w_mn, w_diff;
    logic signed [11:0] w_hn;
    logic [8:0]         w_srs, w_hrs;
    logic               w_sbit, w_hbit;
    logic [28:0]        w_ssum;
    logic signed [30:0] w_hsum, w_hsh;
    logic signed [8:0]  w_hraw;
    logic [7:0]         w_h, w_s;
    logic               w_match;

    // max, min and hue numerator of the incoming pixel
    always_comb begin
        w_v = i_blue;
        if (i_green > w_v) w_v = i_green;
        if (i_red > w_v) w_v = i_red;
        w_mn = i_blue;
        if (i_green < w_mn) w_mn = i_green;
        if (i_red < w_mn) w_mn = i_red;
        w_diff = w_v - w_mn;
        priority if (w_v == i_red) begin
            w_hn = $signed({4'b0, i_green}) - $signed({4'b0, i_blue});
        end else if (w_v == i_green) begin
            w_hn = $signed({4'b0, i_blue}) - $signed({4'b0, i_red})
                 + $signed({3'b0, w_diff, 1'b0});
        end else begin
            w_hn = $signed({4'b0, i_red}) - $signed({4'b0, i_green})
                 + $signed({2'b0, w_diff, 2'b0});
        end
    end

    // one restoring step for each reciprocal
    always_comb begin
        w_srs  = {r_sr[7:0], r_sq[19]};
        w_sbit = (w_srs >= {1'b0, r_v});
        w_hrs  = {r_hr[7:0], r_hq[19]};
        w_hbit = (w_hrs >= {1'b0, r_diff});
    end

    // rounding, hue wrap and bounds test
    always_comb begin
        w_ssum = r_sprod + 29'd2048;
        w_s    = (r_v != 8'd0) ? w_ssum[19:12] : 8'd0;
        w_hsum = r_hprod + 31'sd2048;
        w_hsh  = w_hsum >>> 12;
        w_hraw = w_hsh[8:0];
        if (r_diff == 8'd0) begin
            w_h = 8'd0;
        end else if (w_hraw < 0) begin
            w_h = 8'(w_hraw + $signed(cbcs_pkg::HUE_WRAP));
        end else begin
            w_h = w_hraw[7:0];
        end
        w_match = (w_h >= i_cfg.lower_hsv[23:16]) && (w_h <= i_cfg.upper_hsv[23:16])
               && (w_s >= i_cfg.lower_hsv[15:8])  && (w_s <= i_cfg.upper_hsv[15:8])
               && (r_v >= i_cfg.lower_hsv[7:0])   && (r_v <= i_cfg.upper_hsv[7:0])
               && (r_row >= i_cfg.band_top) && (r_row <= i_cfg.band_bottom)
               && ({2'b0, r_col} < 13'(cbcs_pkg::MAX_WIDTH))
               && ({2'b0, r_row} < 13'(cbcs_pkg::MAX_HEIGHT));
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbcs_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            cbcs_pkg::F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = cbcs_pkg::F_DIV;
            end
            cbcs_pkg::F_DIV: begin
                if (r_cnt == 5'd19) n_state = cbcs_pkg::F_MUL;
            end
            cbcs_pkg::F_MUL: begin
                n_state = cbcs_pkg::F_PUSH;
            end
            cbcs_pkg::F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = cbcs_pkg::F_IDLE;
                end
            end
            default: n_state = cbcs_pkg::F_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == cbcs_pkg::F_IDLE && i_valid) begin
            r_v    <= w_v;
            r_diff <= w_diff;
            r_hn   <= w_hn;
            r_col  <= i_column;
            r_row  <= i_row;
            r_fend <= i_frame_end;
            r_sq   <= cbcs_pkg::SAT_NUM + {13'b0, w_v[7:1]};
            r_hq   <= cbcs_pkg::HUE_NUM + {13'b0, w_diff[7:1]};
            r_sr   <= 9'd0;
            r_hr   <= 9'd0;
            r_cnt  <= 5'd0;
        end
        if (r_state == cbcs_pkg::F_DIV) begin
            r_sr  <= w_sbit ? (w_srs - {1'b0, r_v}) : w_srs;
            r_sq  <= {r_sq[18:0], w_sbit};
            r_hr  <= w_hbit ? (w_hrs - {1'b0, r_diff}) : w_hrs;
            r_hq  <= {r_hq[18:0], w_hbit};
            r_cnt <= r_cnt + 5'd1;
        end
        if (r_state == cbcs_pkg::F_MUL) begin
            r_sprod <= 29'({21'b0, r_diff} * {9'b0, r_sq});
            r_hprod <= 31'($signed({{19{r_hn[11]}}, r_hn}) * $signed({11'b0, r_hq[19:0]}));
        end
    end

    assign o_item.match     = w_match;
    assign o_item.column    = r_col;
    assign o_item.row       = r_row;
    assign o_item.frame_end = r_fend;

endmodule

### hw/rtl/cbcs_fifo.sv
// short queue of classified pixels between front and back
module cbcs_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cbcs_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output cbcs_pkg::t_item o_item,
    output logic            o_empty
);

    localparam int unsigned AW = $clog2(cbcs_pkg::QUEUE_DEPTH);

    cbcs_pkg::t_item r_mem [cbcs_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_fill;

    assign o_full  = (r_fill == (AW+1)'(cbcs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_item  = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            r_fill <= r_fill + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule

### hw/rtl/cbcs_back.sv
// back: accumulation, frame-end centroid division and drive computation
module cbcs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbcs_pkg::t_cfg  i_cfg,
    input  cbcs_pkg::t_item i_item,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [8:0]      o_left_drive,
    output logic [8:0]      o_right_drive,
    output logic            o_line_found,
    output logic [10:0]     o_centroid_x,
    output logic [10:0]     o_centroid_y
);

    localparam int unsigned CW = cbcs_pkg::COUNT_W;
    localparam int unsigned SW = cbcs_pkg::SUM_W;

    cbcs_pkg::t_back_state r_state, n_state;

    logic [CW-1:0] r_count;
    logic [SW-1:0] r_csum, r_rsum;
    logic [SW-1:0] r_cq, r_rq;
    logic [CW-1:0] r_cr, r_rr;
    logic [5:0]    r_cnt;
    logic [10:0]   r_cx, r_cy;
    logic [10:0]   r_abs;
    logic          r_neg;
    logic [24:0]   r_prod;
    logic          r_out_valid;
    logic [8:0]    r_left, r_right;
    logic          r_found;
    logic [10:0]   r_ox, r_oy;

    logic [CW:0]        w_crs, w_rrs;
    logic               w_cbit, w_rbit;
    logic signed [11:0] w_err;
    logic [4:0]         w_q;
    logic signed [9:0]  w_left;
    logic               w_emit;

    // one restoring step for both quotients
    always_comb begin
        w_crs  = {r_cr, r_cq[SW-1]};
        w_cbit = (w_crs >= {1'b0, r_count});
        w_rrs  = {r_rr, r_rq[SW-1]};
        w_rbit = (w_rrs >= {1'b0, r_count});
    end

    // steering error from the finished column quotient and truncated gain
    always_comb begin
        w_err  = $signed({1'b0, r_cq[10:0]}) - $signed({2'b0, i_cfg.center_column});
        w_q    = r_prod[cbcs_pkg::GAIN_SHIFT +: 5];
        w_left = r_neg ? (10'sd10 - $signed({5'b0, w_q})) : (10'sd10 + $signed({5'b0, w_q}));
        if (w_left > 10'(cbcs_pkg::DRIVE_LIMIT)) w_left = 10'(cbcs_pkg::DRIVE_LIMIT);
        if (w_left < -10'(cbcs_pkg::DRIVE_LIMIT)) w_left = -10'(cbcs_pkg::DRIVE_LIMIT);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbcs_pkg::B_POP;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and queue pop
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_emit  = 1'b0;
        unique case (r_state)
            cbcs_pkg::B_POP: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_item.frame_end) n_state = cbcs_pkg::B_END;
                end
            end
            cbcs_pkg::B_END: begin
                n_state = (r_count == '0) ? cbcs_pkg::B_EMIT : cbcs_pkg::B_DIV;
            end
            cbcs_pkg::B_DIV: begin
                if (r_cnt == 6'(SW-1)) n_state = cbcs_pkg::B_ERR;
            end
            cbcs_pkg::B_ERR: n_state = cbcs_pkg::B_MUL;
            cbcs_pkg::B_MUL: n_state = cbcs_pkg::B_EMIT;
            cbcs_pkg::B_EMIT: begin
                if (!r_out_valid) begin
                    w_emit  = 1'b1;
                    n_state = cbcs_pkg::B_POP;
                end
            end
            default: n_state = cbcs_pkg::B_POP;
        endcase
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_csum  <= '0;
            r_rsum  <= '0;
        end else if (w_emit) begin
            r_count <= '0;
            r_csum  <= '0;
            r_rsum  <= '0;
        end else if (o_pop && i_item.match && r_count != cbcs_pkg::COUNT_MAX) begin
            r_count <= r_count + 1'b1;
            r_csum  <= r_csum + SW'(i_item.column);
            r_rsum  <= r_rsum + SW'(i_item.row);
        end
    end

    // division and drive datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cbcs_pkg::B_END: begin
                r_cq  <= r_csum;
                r_rq  <= r_rsum;
                r_cr  <= '0;
                r_rr  <= '0;
                r_cnt <= '0;
                r_cx  <= '0;
                r_cy  <= '0;
            end
            cbcs_pkg::B_DIV: begin
                r_cr  <= w_cbit ? CW'(w_crs - {1'b0, r_count}) : w_crs[CW-1:0];
                r_cq  <= {r_cq[SW-2:0], w_cbit};
                r_rr  <= w_rbit ? CW'(w_rrs - {1'b0, r_count}) : w_rrs[CW-1:0];
                r_rq  <= {r_rq[SW-2:0], w_rbit};
                r_cnt <= r_cnt + 6'd1;
            end
            cbcs_pkg::B_ERR: begin
                r_cx   <= r_cq[10:0];
                r_cy   <= r_rq[10:0];
                r_neg  <= w_err[11];
                r_abs  <= w_err[11] ? 11'(-w_err) : w_err[10:0];
            end
            default: ;
        endcase
        r_prod <= 25'({14'b0, r_abs} * {11'b0, cbcs_pkg::GAIN_RECIP});
    end

    // output register, parts the back from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_count == '0) begin
                r_left  <= 9'(cbcs_pkg::IDLE_LEFT);
                r_right <= 9'(cbcs_pkg::IDLE_RIGHT);
                r_found <= 1'b0;
                r_ox    <= '0;
                r_oy    <= '0;
            end else begin
                r_left  <= w_left[8:0];
                r_right <= 9'(cbcs_pkg::DRIVE_BASE);
                r_found <= 1'b1;
                r_ox    <= r_cx;
                r_oy    <= r_cy;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;
    assign o_line_found  = r_found;
    assign o_centroid_x  = r_ox;
    assign o_centroid_y  = r_oy;

endmodule
